[src/irma_pkg.sv]
// ----------------------------------------------------------------------------
// irma_pkg
// Shared field widths, conversion constants and register codes for the
// infrared range moving-average unit.
// ----------------------------------------------------------------------------
package irma_pkg;

  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned HELD_W     = 5;
  localparam int unsigned WLEN_W     = 5;
  localparam int unsigned MASK_W     = 8;

  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 24;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned SAMPLE_MAX  = 1023;
  localparam int unsigned RANGE_SCALE = 20760;
  localparam int unsigned DARK_LEVEL  = 11;
  localparam int unsigned RANGE_MAX   = 65535;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd10;
  localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_CHANNEL_MASK  = 1'b1
  } cfg_reg_e;

endpackage

[src/irma_ring_mem.sv]
// ----------------------------------------------------------------------------
// irma_ring_mem
// Sample store: one window of recent readings per channel, one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module irma_ring_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [irma_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [irma_pkg::SAMPLE_W-1:0] rdata_o
);
  import irma_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/irma_chan_mem.sv]
// ----------------------------------------------------------------------------
// irma_chan_mem
// Per-channel window state (sum, fill count, write pointer). Valid bits
// make an entry not yet written read as zero after reset.
// ----------------------------------------------------------------------------
module irma_chan_mem #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned AW      = 3,
  parameter int unsigned DW      = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [DW-1:0]      rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[src/irma_divider.sv]
// ----------------------------------------------------------------------------
// irma_divider
// Restoring divider, one quotient bit per cycle; NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
module irma_divider #(
  parameter int unsigned NUM_W = 19,
  parameter int unsigned DEN_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned IT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [IT_W-1:0]  iter_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic             take;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    take   = (rem_sh >= {1'b0, den_q});
    rem_d  = take ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
    quo_d  = {quo_q[NUM_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= IT_W'(NUM_W);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == IT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[src/ir_range_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// ir_range_moving_average_unit
// Per-channel moving average of infrared range readings, converted to mm.
// Flow: the divider is skipped when the distance is invalid. A new word is
//   taken only once the last result has entered the output register; a
//   result may wait there while the next word is taken. Disabled channels
//   are taken and give no result.
// Reset: channel state reads as zero through valid bits at once, no clearing
//   pass; the sample store is left as it is.
// ----------------------------------------------------------------------------
module ir_range_moving_average_unit #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream: [2:0] channel, [12:3] sample_value, [15:13] zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [irma_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // output stream: [2:0] out_channel, [18:3] range_mm, [23:19] samples_held
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [irma_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] no_distance
  output logic                            m_axis_tuser,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [irma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [irma_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import irma_pkg::*;

  // Derived sizes
  localparam int unsigned RING_DEPTH = CHANNELS * MAX_WINDOW;
  localparam int unsigned RA_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WP_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = $clog2(MAX_WINDOW * SAMPLE_MAX + 1);
  localparam int unsigned NUM_W = $clog2(RANGE_SCALE * MAX_WINDOW + 1);
  localparam int unsigned CS_W  = SUM_W + CNT_W + WP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CHAN,
    ST_RD_RING,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [WLEN_W-1:0] wlen_q;
  logic [MASK_W-1:0] mask_q;

  // Working registers for the word in flight
  logic [CHAN_W-1:0]   ch_q;
  logic [SAMPLE_W-1:0] val_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [WP_W-1:0]     wp_q;
  logic                full_q;
  logic [RANGE_W-1:0]  range_q;
  logic                invalid_q;

  // Output register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic                 m_user_q;

  // Memory ports
  logic [CS_W-1:0]     cs_rdata;
  logic [CS_W-1:0]     cs_wdata;
  logic [RA_W-1:0]     ring_base;
  logic [RA_W-1:0]     ring_raddr;
  logic [RA_W-1:0]     ring_waddr;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic                upd_we;

  // Read-side decode
  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;
  logic [WP_W-1:0]   rd_wp;
  logic [CNT_W-1:0]  eff_len;
  logic              rd_full;
  logic [WP_W:0]     old_ext;
  logic [WP_W-1:0]   old_idx;

  // Update and conversion
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [WP_W-1:0]   wp_new;
  logic [SUM_W-1:0]  dark;
  logic              calc_invalid;
  logic [NUM_W-1:0]  div_num;
  logic [SUM_W-1:0]  div_den;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [RANGE_W-1:0] range_sat;

  logic [CHAN_W-1:0]   in_ch;
  logic [SAMPLE_W-1:0] in_val;
  logic                in_take;
  logic                out_load;

  assign in_ch   = s_axis_tdata[CHAN_W-1:0];
  assign in_val  = s_axis_tdata[CHAN_W +: SAMPLE_W];
  assign in_take = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (wlen_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(wlen_q) > MAX_WINDOW) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(wlen_q);
    end
  end

  // Channel state arrives in the cycle after accept (registered read)
  assign {rd_sum, rd_cnt, rd_wp} = cs_rdata;
  assign rd_full = (rd_cnt >= eff_len);

  // Oldest slot: (wp - cnt) mod MAX_WINDOW; operand stays below 2*MAX_WINDOW
  always_comb begin
    old_ext = {1'b0, rd_wp} + (WP_W + 1)'(MAX_WINDOW) - (WP_W + 1)'(rd_cnt);
    if (int'(old_ext) >= MAX_WINDOW) begin
      old_ext = old_ext - (WP_W + 1)'(MAX_WINDOW);
    end
    old_idx = WP_W'(old_ext);
  end

  assign ring_base  = RA_W'(int'(ch_q) * MAX_WINDOW);
  assign ring_raddr = ring_base + RA_W'(old_idx);
  assign ring_waddr = ring_base + RA_W'(wp_q);

  // Read-modify-write of the window; the oldest sample is read before the
  // new one overwrites its slot when the window spans the whole ring.
  always_comb begin
    sum_new = sum_q - (full_q ? SUM_W'(ring_rdata) : '0) + SUM_W'(val_q);
    cnt_new = full_q ? cnt_q : cnt_q + 1'b1;
    wp_new  = (int'(wp_q) + 1 == MAX_WINDOW) ? '0 : wp_q + 1'b1;
  end

  assign upd_we   = (state_q == ST_RD_RING);
  assign cs_wdata = {sum_new, cnt_new, wp_new};

  // range = RANGE_SCALE*cnt / (sum - DARK_LEVEL*cnt)
  assign dark         = SUM_W'(DARK_LEVEL * cnt_q);
  assign calc_invalid = (sum_q <= dark);
  assign div_num      = NUM_W'(RANGE_SCALE * cnt_q);
  assign div_den      = sum_q - dark;
  assign div_start    = (state_q == ST_CALC) && !calc_invalid;
  assign range_sat    = (int'(div_quo) > RANGE_MAX) ? RANGE_W'(RANGE_MAX)
                                                    : RANGE_W'(div_quo);

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  irma_chan_mem #(
    .ENTRIES (CHANNELS),
    .AW      (CH_W),
    .DW      (CS_W)
  ) u_chan_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (upd_we),
    .waddr_i (CH_W'(ch_q)),
    .wdata_i (cs_wdata),
    .raddr_i (CH_W'(in_ch)),
    .rdata_o (cs_rdata)
  );

  irma_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (RA_W)
  ) u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (upd_we),
    .waddr_i (ring_waddr),
    .wdata_i (val_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  irma_divider #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wlen_q    <= WLEN_RESET;
      mask_q    <= MASK_RESET;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_WINDOW_LENGTH: wlen_q <= cfg_data_i[WLEN_W-1:0];
          CFG_CHANNEL_MASK:  mask_q <= cfg_data_i[MASK_W-1:0];
          default: ;
        endcase
      end

      // a new word may replace the one leaving in the same cycle
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          // out-of-range or disabled channel: taken, no result
          if (in_take && (int'(in_ch) < CHANNELS) && mask_q[in_ch]) begin
            state_q <= ST_RD_CHAN;
          end
        end
        ST_RD_CHAN: state_q <= ST_RD_RING;
        ST_RD_RING: state_q <= ST_CALC;
        ST_CALC: begin
          state_q <= calc_invalid ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q  <= in_ch;
      val_q <= in_val;
    end
    if (state_q == ST_RD_CHAN) begin
      sum_q  <= rd_sum;
      cnt_q  <= rd_cnt;
      wp_q   <= rd_wp;
      full_q <= rd_full;
    end
    if (state_q == ST_RD_RING) begin
      sum_q <= sum_new;
      cnt_q <= cnt_new;
    end
    if (state_q == ST_CALC) begin
      invalid_q <= calc_invalid;
      range_q   <= '0;
    end
    if ((state_q == ST_DIV) && div_done) begin
      range_q <= range_sat;
    end
    if (out_load) begin
      m_data_q <= {HELD_W'(cnt_q), range_q, ch_q};
      m_user_q <= invalid_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Assertions
  a_result_from_done: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE)
  ) else $error("result word raised outside the done step");

  a_div_done_in_div: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV)
  ) else $error("divider finished while sequencer not waiting on it");

  a_invalid_zero_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[CHAN_W +: RANGE_W] == '0)
  ) else $error("no-distance word carries a non-zero range");

endmodule

[verif/ir_range_moving_average_unit_tb.sv]
// ----------------------------------------------------------------------------
// ir_range_moving_average_unit_tb
// Self-checking bench for the infrared range moving-average unit. A driver
// streams sample words from a queue, a local per-channel window model predicts
// each range word, and a monitor compares every output word in order. The run
// steps through several window lengths and channel masks, each under an
// idle and back-pressure pattern.
// ----------------------------------------------------------------------------
module ir_range_moving_average_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irma_pkg::*;

  localparam int unsigned N_CHAN      = 8;
  localparam int unsigned WIN_DEPTH   = 16;
  // drain time, longer than one full division by the divider
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned PHASE_WORDS  = 125;
  localparam int unsigned MAX_REPORTS  = 10;

  // one result word as the monitor sees it
  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [RANGE_W-1:0] range_mm;
    logic               no_dist;
    logic [HELD_W-1:0]  held;
  } range_word_t;

  typedef struct {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] value;
  } sample_word_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // block ports, all driven from time zero
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  ir_range_moving_average_unit #(
    .CHANNELS   (N_CHAN),
    .MAX_WINDOW (WIN_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Window model: a copy of the per-channel state and the two registers
  // --------------------------------------------------------------------------
  logic [WLEN_W-1:0]   win_len   = WLEN_RESET;
  logic [MASK_W-1:0]   chan_mask = MASK_RESET;
  logic [SAMPLE_W-1:0] win_ring [N_CHAN*WIN_DEPTH] = '{default: '0};
  int unsigned         win_sum  [N_CHAN] = '{default: 0};
  int unsigned         win_fill [N_CHAN] = '{default: 0};
  int unsigned         win_ptr  [N_CHAN] = '{default: 0};

  range_word_t  range_expect_q[$];
  sample_word_t sample_pend_q[$];

  // bookkeeping shared by driver, monitor and sequencer
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_queued   = 0;
  int unsigned words_taken    = 0;
  int unsigned ranges_checked = 0;
  int unsigned invalid_seen   = 0;
  int unsigned saturated_seen = 0;
  int unsigned fail_count     = 0;
  int unsigned settings_run   = 0;
  int unsigned cycle_count    = 0;

  // Push one sample into its channel window and queue the range it gives.
  // Disabled channels leave the state alone and give nothing.
  function automatic void update_window(input logic [CHAN_W-1:0] ch,
                                        input logic [SAMPLE_W-1:0] v);
    int unsigned len, cnt, sum, wp, oldest, dark, quot;
    range_word_t w;
    if (!chan_mask[ch]) return;
    len = win_len;
    if (len < 1) len = 1;
    if (len > WIN_DEPTH) len = WIN_DEPTH;
    wp  = win_ptr[ch];
    cnt = win_fill[ch];
    sum = win_sum[ch];
    // full window drops its oldest; a shortened window keeps its larger size
    if (cnt >= len && cnt >= 1) begin
      oldest = (wp + WIN_DEPTH - cnt) % WIN_DEPTH;
      sum -= win_ring[ch*WIN_DEPTH + oldest];
    end else begin
      cnt++;
    end
    win_ring[ch*WIN_DEPTH + wp] = v;
    sum += v;
    wp = (wp + 1) % WIN_DEPTH;
    win_sum[ch]  = sum;
    win_fill[ch] = cnt;
    win_ptr[ch]  = wp;

    dark       = DARK_LEVEL * cnt;
    w.chan     = ch;
    w.no_dist  = (sum <= dark);
    w.range_mm = '0;
    if (!w.no_dist) begin
      quot = (RANGE_SCALE * cnt) / (sum - dark);
      if (quot > RANGE_MAX) quot = RANGE_MAX;
      w.range_mm = quot[RANGE_W-1:0];
    end
    w.held = cnt[HELD_W-1:0];
    range_expect_q = {range_expect_q, w};
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("  mismatch: %s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued sample words, holding each until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_driver
    sample_word_t nxt;
    if (s_axis_tvalid && s_axis_tready) begin
      update_window(s_axis_tdata[CHAN_W-1:0], s_axis_tdata[CHAN_W +: SAMPLE_W]);
      words_taken++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (sample_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = sample_pend_q[0];
        sample_pend_q.delete(0);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-CHAN_W-SAMPLE_W){1'b0}}, nxt.value, nxt.chan};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each range word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : range_monitor
    range_word_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.chan     = m_axis_tdata[CHAN_W-1:0];
      got.range_mm = m_axis_tdata[CHAN_W +: RANGE_W];
      got.held     = m_axis_tdata[CHAN_W+RANGE_W +: HELD_W];
      got.no_dist  = m_axis_tuser;
      if (range_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected word ch=%0d range=%0d nd=%0b held=%0d",
                               got.chan, got.range_mm, got.no_dist, got.held));
      end else begin
        want = range_expect_q[0];
        range_expect_q.delete(0);
        ranges_checked++;
        if (want.no_dist) invalid_seen++;
        if (want.range_mm == RANGE_MAX) saturated_seen++;
        if (got != want)
          note_failure($sformatf(
            "exp ch=%0d range=%0d nd=%0b held=%0d, got ch=%0d range=%0d nd=%0b held=%0d",
            want.chan, want.range_mm, want.no_dist, want.held,
            got.chan, got.range_mm, got.no_dist, got.held));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer helpers
  // --------------------------------------------------------------------------
  task automatic queue_sample(input int unsigned ch, input int unsigned v);
    sample_word_t s;
    s.chan  = ch[CHAN_W-1:0];
    s.value = v[SAMPLE_W-1:0];
    sample_pend_q = {sample_pend_q, s};
    words_queued++;
  endtask

  // every queued word taken, every range in, then a drain period before
  // the next register writes
  task automatic wait_quiet();
    while (words_taken != words_queued || range_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WINDOW_LENGTH: win_len   = data[WLEN_W-1:0];
      CFG_CHANNEL_MASK:  chan_mask = data[MASK_W-1:0];
      default: ;
    endcase
  endtask

  // Random samples, mostly on one hot channel so windows fill and wrap.
  // Values lean towards the dark level where validity and saturation flip.
  // The target counts every queued word, disabled channels included.
  task automatic random_phase(input int unsigned target);
    int unsigned live, hot, ch, v, pick;
    live = 0;
    hot  = $urandom_range(N_CHAN-1);
    while (live < target) begin
      if ($urandom_range(99) < 10) hot = $urandom_range(N_CHAN-1);
      ch   = ($urandom_range(99) < 50) ? hot : $urandom_range(N_CHAN-1);
      pick = $urandom_range(99);
      if (pick < 35)      v = $urandom_range(SAMPLE_MAX);
      else if (pick < 65) v = $urandom_range(30, 5);
      else if (pick < 80) v = $urandom_range(14, 9);
      else if (pick < 90) v = $urandom_range(1) ? SAMPLE_MAX : 0;
      else                v = $urandom_range(300, 100);
      queue_sample(ch, v);
      live++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] ph_len  [8] = '{8'hE0, 8'd16, 8'd4, 8'hFF,
                                         8'd1,  8'd12, 8'd17, 8'd7};
  logic [CFG_DATA_W-1:0] ph_mask [8] = '{8'hFF, 8'hFF, 8'hA5, 8'h3C,
                                         8'hFF, 8'hC3, 8'hFF, 8'h81};
  int unsigned           ph_idle [8] = '{0, 73,  0, 26, 0, 73,  0, 26};
  int unsigned           ph_stall[8] = '{0,  0, 73, 26, 0,  0, 73, 26};

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: length 10, all channels on
    settings_run++;
    queue_sample(0, 0);              // floor reading, invalid
    queue_sample(7, SAMPLE_MAX);     // top reading
    queue_sample(1, DARK_LEVEL);     // average exactly at dark level
    queue_sample(1, 12);             // denominator of one
    repeat (3) queue_sample(2, DARK_LEVEL);
    queue_sample(2, 12);             // range above 16 bits, saturates
    queue_sample(3, 12);
    repeat (10) queue_sample(5, SAMPLE_MAX);
    queue_sample(5, 0);              // full window drops its oldest
    wait_quiet();

    // disabled channels give nothing
    write_reg(CFG_CHANNEL_MASK, 8'h5A);
    settings_run++;
    queue_sample(0, 500);
    queue_sample(1, 500);
    queue_sample(7, 500);
    wait_quiet();

    // window shortened while full keeps its size
    write_reg(CFG_WINDOW_LENGTH, 8'd3);
    write_reg(CFG_CHANNEL_MASK, 8'h00);
    write_reg(CFG_CHANNEL_MASK, 8'hFF);
    settings_run++;
    queue_sample(5, 500);
    queue_sample(6, 700);
    wait_quiet();

    for (int p = 0; p < 8; p++) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_reg(CFG_WINDOW_LENGTH, ph_len[p]);
      write_reg(CFG_CHANNEL_MASK, ph_mask[p]);
      settings_run++;
      send_idle_pct  = ph_idle[p];
      recv_stall_pct = ph_stall[p];
      random_phase(PHASE_WORDS);
      wait_quiet();
    end

    if (range_expect_q.size() != 0)
      note_failure($sformatf("%0d range words never arrived", range_expect_q.size()));

    $display("covered %0d sample words under %0d register settings", words_taken,
             settings_run);
    $display("checked %0d range words, %0d invalid, %0d saturated, %0d failures",
             ranges_checked, invalid_seen, saturated_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
